// ===== rtl/core/vpqs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vpqs_pkg
// Shared types, frame constants and the microcode ROM of the voice prompt
// queue sequencer.
// ----------------------------------------------------------------------------
package vpqs_pkg;

   // Request modes
   localparam logic [2:0] MODE_INIT    = 3'd0;
   localparam logic [2:0] MODE_ENQUEUE = 3'd1;
   localparam logic [2:0] MODE_URGENT  = 3'd2;
   localparam logic [2:0] MODE_STOP    = 3'd3;
   localparam logic [2:0] MODE_UPDATE  = 3'd4;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_VOLUME  = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT = 2'd1;

   localparam logic [4:0]  VOLUME_RESET  = 5'd20;
   localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

   // Frame bytes: 7E FF 06 cmd 00 p1 p2 EF
   localparam logic [7:0] FRAME_SOF  = 8'h7E;
   localparam logic [7:0] FRAME_VER  = 8'hFF;
   localparam logic [7:0] FRAME_LEN  = 8'h06;
   localparam logic [7:0] FRAME_EOF  = 8'hEF;
   localparam logic [7:0] CMD_PLAY   = 8'h03;
   localparam logic [7:0] CMD_STOP   = 8'h16;
   localparam logic [7:0] CMD_VOLUME = 8'h06;

   localparam int STEP_W = 6;
   typedef logic [STEP_W-1:0] step_type;

   // Microprogram layout
   localparam step_type ST_DISPATCH      = 6'd0;
   localparam step_type ST_INIT          = 6'd1;
   localparam step_type ST_INIT_FRAME    = 6'd2;
   localparam step_type ST_INIT_END      = 6'd9;
   localparam step_type ST_ENQUEUE       = 6'd10;
   localparam step_type ST_NOBYTE        = 6'd11;
   localparam step_type ST_URGENT        = 6'd12;
   localparam step_type ST_URG_STOP      = 6'd13;
   localparam step_type ST_URG_STOP_END  = 6'd20;
   localparam step_type ST_PLAY          = 6'd21;
   localparam step_type ST_PLAY_END      = 6'd28;
   localparam step_type ST_STOP          = 6'd29;
   localparam step_type ST_STOP_FRAME    = 6'd30;
   localparam step_type ST_STOP_END      = 6'd37;
   localparam step_type ST_UPDATE        = 6'd38;
   localparam step_type ST_POP           = 6'd39;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_INIT,
      OP_ENQUEUE,
      OP_URGENT,
      OP_STOP,
      OP_UPDATE,
      OP_POP
   } op_type;

   typedef enum logic [1:0] {
      BR_NEXT,
      BR_MODE,
      BR_POP,
      BR_GOTO
   } branch_type;

   typedef struct packed {
      op_type     op;
      logic       emit;
      logic [2:0] pos;
      logic [7:0] cmd;
      logic       p2_zero;
      logic       last;
      branch_type branch;
      step_type   target;
   } uword_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [7:0]  track_id;
      logic        busy_pin_high;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] frame_byte;
      logic       last_result;
      logic       busy_now;
      logic       dropped;
   } rsp_type;

   function automatic uword_type ucode_rom(step_type addr);
      uword_type w;
      w = '{op: OP_NONE, emit: 1'b0, pos: 3'd0, cmd: 8'h00, p2_zero: 1'b0,
            last: 1'b0, branch: BR_NEXT, target: ST_DISPATCH};
      case (addr) inside
         ST_DISPATCH: w.branch = BR_MODE;
         ST_INIT:     w.op = OP_INIT;
         [ST_INIT_FRAME:ST_INIT_END]: begin
            w.emit = 1'b1;
            w.pos  = 3'(addr - ST_INIT_FRAME);
            w.cmd  = CMD_VOLUME;
            w.last = (addr == ST_INIT_END);
         end
         ST_ENQUEUE:  w.op = OP_ENQUEUE;
         ST_NOBYTE:   w.last = 1'b1;
         ST_URGENT:   w.op = OP_URGENT;
         [ST_URG_STOP:ST_URG_STOP_END]: begin
            w.emit    = 1'b1;
            w.pos     = 3'(addr - ST_URG_STOP);
            w.cmd     = CMD_STOP;
            w.p2_zero = 1'b1;
         end
         [ST_PLAY:ST_PLAY_END]: begin
            w.emit = 1'b1;
            w.pos  = 3'(addr - ST_PLAY);
            w.cmd  = CMD_PLAY;
            w.last = (addr == ST_PLAY_END);
         end
         ST_STOP:     w.op = OP_STOP;
         [ST_STOP_FRAME:ST_STOP_END]: begin
            w.emit    = 1'b1;
            w.pos     = 3'(addr - ST_STOP_FRAME);
            w.cmd     = CMD_STOP;
            w.p2_zero = 1'b1;
            w.last    = (addr == ST_STOP_END);
         end
         ST_UPDATE: begin
            w.op     = OP_UPDATE;
            w.branch = BR_POP;
            w.target = ST_POP;
         end
         ST_POP: begin
            w.op     = OP_POP;
            w.branch = BR_GOTO;
            w.target = ST_PLAY;
         end
         default:     w.last = 1'b1;
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/vpqs_useq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vpqs_useq
// Step counter and microcode ROM; resolves the mode dispatch and the
// pop branch, ends the program on a word marked last.
// ----------------------------------------------------------------------------
module vpqs_useq
   import vpqs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start_accept,
   input  wire logic [2:0] mode,
   input  wire logic       pop_cond,
   output logic            running,
   output uword_type       uword
);

   step_type step_ff, step_in;
   logic     running_ff, running_in;
   step_type mode_target;

   assign uword   = ucode_rom(step_ff);
   assign running = running_ff;

   always_comb begin
      unique case (mode)
         MODE_INIT:    mode_target = ST_INIT;
         MODE_ENQUEUE: mode_target = ST_ENQUEUE;
         MODE_URGENT:  mode_target = ST_URGENT;
         MODE_STOP:    mode_target = ST_STOP;
         MODE_UPDATE:  mode_target = ST_UPDATE;
         default:      mode_target = ST_NOBYTE;
      endcase
   end

   always_comb begin
      step_in    = step_ff;
      running_in = running_ff;
      if (start_accept) begin
         step_in    = ST_DISPATCH;
         running_in = 1'b1;
      end else if (running_ff) begin
         if (uword.last) begin
            running_in = 1'b0;
         end else begin
            unique case (uword.branch)
               BR_NEXT: step_in = step_ff + 1'b1;
               BR_MODE: step_in = mode_target;
               BR_POP:  step_in = pop_cond ? uword.target : ST_NOBYTE;
               BR_GOTO: step_in = uword.target;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= ST_DISPATCH;
         running_ff <= 1'b0;
      end else begin
         step_ff    <= step_in;
         running_ff <= running_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/voice_prompt_queue_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// voice_prompt_queue_sequencer
// Track queue and command framer for a serial voice-prompt chip, run by a
// microcoded sequencer. Commands go out as 8-byte frames; an enqueue sends none.
// ----------------------------------------------------------------------------
// Results: after the accepting edge the beats follow one a cycle; results cannot stall.
// Occupancy (busy high) is set by the microprogram steps of each mode; the next
//   command is taken the cycle busy falls.
// Reset clears queue indexes, busy flag and start time and loads register defaults.
module voice_prompt_queue_sequencer
   import vpqs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_data,
   output logic             rsp_strobe,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

   logic       start_accept;
   logic       running;
   uword_type  uword;
   logic       pop_cond;

   req_type    item_ff;
   logic [4:0]  volume_ff;
   logic [15:0] timeout_ff;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in, rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0] wr_next, rd_next;
   logic        busy_flag_ff, busy_flag_in;
   logic [31:0] start_time_ff, start_time_in;
   logic [7:0]  p2_ff, p2_in;
   logic        dropped_ff, dropped_in;
   logic [7:0]  rd_data_ff;
   logic [7:0]  mem [QUEUE_DEPTH];
   logic        mem_we;
   logic        full;
   logic [31:0] elapsed;
   logic        timed_out;
   op_type      op;

   logic        rsp_strobe_ff, rsp_strobe_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic [7:0]  frame_byte;

   assign start_accept = start & ~running;
   assign busy         = running;
   assign csr_ready    = 1'b1;
   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_data     = rsp_data_ff;

   vpqs_useq u_useq (
      .clock        (clock),
      .reset        (reset),
      .start_accept (start_accept),
      .mode         (item_ff.mode),
      .pop_cond     (pop_cond),
      .running      (running),
      .uword        (uword)
   );

   assign op        = running ? uword.op : OP_NONE;
   assign wr_next   = (wr_idx_ff == IDX_LAST) ? '0 : wr_idx_ff + 1'b1;
   assign rd_next   = (rd_idx_ff == IDX_LAST) ? '0 : rd_idx_ff + 1'b1;
   assign full      = (wr_next == rd_idx_ff);
   assign pop_cond  = ~busy_flag_ff & (wr_idx_ff != rd_idx_ff);
   assign elapsed   = item_ff.now_ms - start_time_ff;  // wraps mod 2^32
   assign timed_out = (elapsed >= {16'h0000, timeout_ff});
   assign mem_we    = (op == OP_ENQUEUE) & ~full;

   always_comb begin
      wr_idx_in     = wr_idx_ff;
      rd_idx_in     = rd_idx_ff;
      busy_flag_in  = busy_flag_ff;
      start_time_in = start_time_ff;
      p2_in         = p2_ff;
      dropped_in    = dropped_ff;
      if (start_accept) begin
         dropped_in = 1'b0;
      end
      unique case (op)
         OP_NONE: ;
         OP_INIT: begin
            wr_idx_in    = '0;
            rd_idx_in    = '0;
            busy_flag_in = 1'b0;
            p2_in        = {3'b000, volume_ff};
         end
         OP_ENQUEUE: begin
            if (full) begin
               dropped_in = 1'b1;
            end else begin
               wr_idx_in = wr_next;
            end
         end
         OP_URGENT: begin
            wr_idx_in     = '0;
            rd_idx_in     = '0;
            busy_flag_in  = 1'b1;
            start_time_in = item_ff.now_ms;
            p2_in         = item_ff.track_id;
         end
         OP_STOP: begin
            wr_idx_in    = '0;
            rd_idx_in    = '0;
            busy_flag_in = 1'b0;
         end
         OP_UPDATE: begin
            if (busy_flag_ff && (item_ff.busy_pin_high || timed_out)) begin
               busy_flag_in = 1'b0;
            end
         end
         OP_POP: begin
            // rd_data_ff already holds the head entry
            rd_idx_in     = rd_next;
            busy_flag_in  = 1'b1;
            start_time_in = item_ff.now_ms;
            p2_in         = rd_data_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      case (uword.pos)
         3'd0:    frame_byte = FRAME_SOF;
         3'd1:    frame_byte = FRAME_VER;
         3'd2:    frame_byte = FRAME_LEN;
         3'd3:    frame_byte = uword.cmd;
         3'd6:    frame_byte = uword.p2_zero ? 8'h00 : p2_ff;
         3'd7:    frame_byte = FRAME_EOF;
         default: frame_byte = 8'h00;
      endcase
   end

   always_comb begin
      rsp_strobe_in           = running & (uword.emit | uword.last);
      rsp_data_in.byte_valid  = uword.emit;
      rsp_data_in.frame_byte  = uword.emit ? frame_byte : 8'h00;
      rsp_data_in.last_result = uword.last;
      rsp_data_in.busy_now    = busy_flag_ff;
      rsp_data_in.dropped     = uword.emit ? 1'b0 : dropped_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff     <= '0;
         rd_idx_ff     <= '0;
         busy_flag_ff  <= 1'b0;
         start_time_ff <= '0;
         volume_ff     <= VOLUME_RESET;
         timeout_ff    <= TIMEOUT_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         wr_idx_ff     <= wr_idx_in;
         rd_idx_ff     <= rd_idx_in;
         busy_flag_ff  <= busy_flag_in;
         start_time_ff <= start_time_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_VOLUME:  volume_ff  <= csr_wdata[4:0];
               CSR_TIMEOUT: timeout_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_accept) begin
         item_ff <= req_data;
      end
      p2_ff       <= p2_in;
      dropped_ff  <= dropped_in;
      rsp_data_ff <= rsp_data_in;
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_idx_ff] <= item_ff.track_id;
      end
      rd_data_ff <= mem[rd_idx_ff];
   end

   a_rsp_from_run : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result beat without a running command");

   a_start_runs : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted command did not start the sequencer");

   a_last_ends : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last_result |-> !busy)
      else $error("sequencer still running after the last beat");

   a_drop_beat : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.dropped |-> !rsp_data.byte_valid && rsp_data.last_result)
      else $error("drop flag on a frame beat");

   a_ring_bound : assert property (@(posedge clock) disable iff (reset)
      (wr_idx_ff <= IDX_LAST) && (rd_idx_ff <= IDX_LAST))
      else $error("queue index beyond depth");

endmodule
`default_nettype wire
